/* rtl/core/gpc_pkg.sv */
// shared types, constants and lookup tables of the geomorphon pattern classifier
// no dependencies; imported by every module of the block
package gpc_pkg;

    localparam int NumDir    = 8;
    localparam int NumRot    = 8;
    localparam int NumLane   = 2 * NumRot;
    localparam int NumSide   = 9;
    localparam int CodeW     = 13;
    localparam int MaskW     = 8;
    localparam int CntW      = 4;
    localparam int ClassW    = 4;
    localparam int DevW      = 2;
    localparam int InDataW   = 16;
    localparam int OutDataW  = 48;
    localparam int OutFieldW = CodeW + 2 * MaskW + 2 * CntW + ClassW + DevW;

    // base-3 digit codes: sign plus one
    localparam logic [1:0] DIG_LOWER  = 2'd0;
    localparam logic [1:0] DIG_FLAT   = 2'd1;
    localparam logic [1:0] DIG_HIGHER = 2'd2;

    // largest possible code, all directions higher
    localparam logic [CodeW-1:0] CODE_MAX = 13'd6560;

    typedef logic [1:0]              digit_t;
    typedef logic [NumDir-1:0][1:0]  digvec_t;
    typedef logic [CodeW-1:0]        code_t;
    typedef logic [MaskW-1:0]        mask_t;
    typedef logic [CntW-1:0]         cnt_t;
    typedef logic [DevW-1:0]         dev_t;

    typedef enum logic [ClassW-1:0] {
        LF_FLAT      = 4'd0,
        LF_PEAK      = 4'd1,
        LF_RIDGE     = 4'd2,
        LF_SHOULDER  = 4'd3,
        LF_SPUR      = 4'd4,
        LF_SLOPE     = 4'd5,
        LF_HOLLOW    = 4'd6,
        LF_FOOTSLOPE = 4'd7,
        LF_VALLEY    = 4'd8,
        LF_PIT       = 4'd9
    } landform_t;

    // what one lane finds for its rotation
    typedef struct packed {
        code_t code;
        mask_t hi_mask;
        mask_t lo_mask;
    } lane_res_t;

    // one finished result
    typedef struct packed {
        dev_t      deviation;
        landform_t landform;
        cnt_t      count_lower;
        cnt_t      count_higher;
        mask_t     lower_mask;
        mask_t     higher_mask;
        code_t     canonical_code;
    } out_item_t;

    // powers of three for the digit weights
    localparam code_t POW3 [NumDir] = '{13'd1, 13'd3, 13'd9, 13'd27,
                                        13'd81, 13'd243, 13'd729, 13'd2187};

    // landform by (count_lower row, count_higher column)
    localparam landform_t LAND_TAB [NumSide][NumSide] = '{
        '{LF_FLAT, LF_FLAT, LF_FLAT, LF_FOOTSLOPE, LF_FOOTSLOPE, LF_VALLEY, LF_VALLEY,
          LF_VALLEY, LF_PIT},
        '{LF_FLAT, LF_FLAT, LF_FOOTSLOPE, LF_FOOTSLOPE, LF_FOOTSLOPE, LF_VALLEY, LF_VALLEY,
          LF_VALLEY, LF_FLAT},
        '{LF_FLAT, LF_SHOULDER, LF_SLOPE, LF_SLOPE, LF_HOLLOW, LF_HOLLOW, LF_VALLEY,
          LF_FLAT, LF_FLAT},
        '{LF_SHOULDER, LF_SHOULDER, LF_SLOPE, LF_SLOPE, LF_SLOPE, LF_HOLLOW, LF_FLAT,
          LF_FLAT, LF_FLAT},
        '{LF_SHOULDER, LF_SHOULDER, LF_SPUR, LF_SLOPE, LF_SLOPE, LF_FLAT, LF_FLAT,
          LF_FLAT, LF_FLAT},
        '{LF_RIDGE, LF_RIDGE, LF_SPUR, LF_SPUR, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT},
        '{LF_RIDGE, LF_RIDGE, LF_RIDGE, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT},
        '{LF_RIDGE, LF_RIDGE, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT},
        '{LF_PEAK, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT, LF_FLAT}
    };

    // deviation by (count_lower row, count_higher column)
    localparam dev_t DEV_TAB [NumSide][NumSide] = '{
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0},
        '{2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}
    };

    // sign to digit; the out-of-range pattern 10 counts as lower
    function automatic digit_t to_digit(input logic [1:0] raw);
        digit_t d;
        case (raw)
            2'b00:   d = DIG_FLAT;
            2'b01:   d = DIG_HIGHER;
            default: d = DIG_LOWER;
        endcase
        return d;
    endfunction

    function automatic landform_t land_lookup(input cnt_t n_lo, input cnt_t n_hi);
        landform_t lf;
        if (n_lo < CntW'(NumSide) && n_hi < CntW'(NumSide))
            lf = LAND_TAB[n_lo][n_hi];
        else
            lf = LF_FLAT;
        return lf;
    endfunction

    function automatic dev_t dev_lookup(input cnt_t n_lo, input cnt_t n_hi);
        dev_t dv;
        if (n_lo < CntW'(NumSide) && n_hi < CntW'(NumSide))
            dv = DEV_TAB[n_lo][n_hi];
        else
            dv = '0;
        return dv;
    endfunction

endpackage

/* rtl/core/gpc_lane.sv */
// one classification lane: base-3 code and higher/lower masks of one rotated pattern
// depends on gpc_pkg
module gpc_lane
    import gpc_pkg::*;
(
    input  digvec_t   digits,
    output lane_res_t res
);

    // weighted digit sum and direction masks
    always_comb
    begin
        code_t code_acc;
        code_acc = '0;
        res.hi_mask = '0;
        res.lo_mask = '0;
        for (int i = 0; i < NumDir; i++)
        begin
            code_acc = code_acc + CodeW'(digits[i] * POW3[i]);
            res.hi_mask[i] = (digits[i] == DIG_HIGHER);
            res.lo_mask[i] = (digits[i] == DIG_LOWER);
        end
        res.code = code_acc;
    end

endmodule

/* rtl/core/gpc_merge.sv */
// merging stage: two-level registered minimum tree over the lanes, table lookup, output register
// depends on gpc_pkg
module gpc_merge
    import gpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lane_res_t lanes [NumLane],
    input  cnt_t      n_hi,
    input  cnt_t      n_lo,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int Grp1 = NumLane / 4;
    localparam int MGrp = NumRot / 4;

    function automatic code_t min_code(input code_t a, input code_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mask_t min_mask(input mask_t a, input mask_t b);
        return (a < b) ? a : b;
    endfunction

    logic      m1_valid_reg;
    code_t     m1_code_reg [Grp1];
    mask_t     m1_hi_reg   [MGrp];
    mask_t     m1_lo_reg   [MGrp];
    cnt_t      m1_nhi_reg;
    cnt_t      m1_nlo_reg;
    landform_t m1_lf_reg;
    dev_t      m1_dev_reg;

    code_t     m1_code_next [Grp1];
    mask_t     m1_hi_next   [MGrp];
    mask_t     m1_lo_next   [MGrp];

    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic      out_free;
    logic      m1_move;

    assign out_free = !out_valid_reg || out_ready;
    assign m1_move  = m1_valid_reg && out_free;
    assign in_ready = !m1_valid_reg || out_free;

    // first level: groups of four codes and masks; only unmirrored lanes give masks
    always_comb
    begin
        for (int g = 0; g < Grp1; g++)
        begin
            m1_code_next[g] = min_code(min_code(lanes[4*g].code, lanes[4*g+1].code),
                                       min_code(lanes[4*g+2].code, lanes[4*g+3].code));
        end
        for (int g = 0; g < MGrp; g++)
        begin
            m1_hi_next[g] = min_mask(min_mask(lanes[4*g].hi_mask, lanes[4*g+1].hi_mask),
                                     min_mask(lanes[4*g+2].hi_mask, lanes[4*g+3].hi_mask));
            m1_lo_next[g] = min_mask(min_mask(lanes[4*g].lo_mask, lanes[4*g+1].lo_mask),
                                     min_mask(lanes[4*g+2].lo_mask, lanes[4*g+3].lo_mask));
        end
    end

    // second level and result assembly
    always_comb
    begin
        out_item_next.canonical_code = min_code(min_code(m1_code_reg[0], m1_code_reg[1]),
                                                min_code(m1_code_reg[2], m1_code_reg[3]));
        out_item_next.higher_mask    = min_mask(m1_hi_reg[0], m1_hi_reg[1]);
        out_item_next.lower_mask     = min_mask(m1_lo_reg[0], m1_lo_reg[1]);
        out_item_next.count_higher   = m1_nhi_reg;
        out_item_next.count_lower    = m1_nlo_reg;
        out_item_next.landform       = m1_lf_reg;
        out_item_next.deviation      = m1_dev_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                m1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= m1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            m1_code_reg <= m1_code_next;
            m1_hi_reg   <= m1_hi_next;
            m1_lo_reg   <= m1_lo_next;
            m1_nhi_reg  <= n_hi;
            m1_nlo_reg  <= n_lo;
            m1_lf_reg   <= land_lookup(n_lo, n_hi);
            m1_dev_reg  <= dev_lookup(n_lo, n_hi);
        end
        if (m1_move)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/core/geomorphon_pattern_classifier_top.sv */
// top level of the geomorphon pattern classifier: input stage, sixteen rotation lanes, merge
// depends on gpc_pkg, gpc_lane and gpc_merge
//
// One eight-direction sign pattern is taken per transfer and one result is given per
// transfer, at a sustained rate of one item every clock cycle while m_tready stays high.
// An input transfer passes through a lane stage where sixteen lanes (eight rotations of
// the pattern and eight of its mirror) form base-3 codes and direction masks, then two
// registered levels of the minimum tree that also hold the landform table lookup. Each
// stage has its own valid flag, so the input keeps accepting while a result waits on the
// output until the pipeline is full. A sign pattern of 10 is taken as lower.
module geomorphon_pattern_classifier_top
    import gpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // dir0_sign[1:0], dir1_sign[3:2], ... dir7_sign[15:14]
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // canonical_code[12:0], higher_mask[20:13], lower_mask[28:21], count_higher[32:29],
    // count_lower[36:33], landform[40:37], deviation[42:41], zero[47:43]
    output logic [OutDataW-1:0] m_tdata
);

    logic      s0_valid_reg;
    digvec_t   s0_dig_reg;
    digvec_t   dig_next;
    digvec_t   rot_dig [NumLane];
    lane_res_t lane_res [NumLane];
    cnt_t      n_hi;
    cnt_t      n_lo;
    logic      merge_ready;
    out_item_t out_item;

    assign s_tready = !s0_valid_reg || merge_ready;

    // sign to digit conversion
    always_comb
    begin
        for (int i = 0; i < NumDir; i++)
            dig_next[i] = to_digit(s_tdata[2*i +: 2]);
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_tready)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            s0_dig_reg <= dig_next;
    end

    // rotation lanes: lanes 0..7 rotate the pattern, lanes 8..15 its mirror
    for (genvar r = 0; r < NumRot; r++)
    begin : g_rot
        for (genvar i = 0; i < NumDir; i++)
        begin : g_dir
            assign rot_dig[r][i]          = s0_dig_reg[(i + NumDir - r) % NumDir];
            assign rot_dig[NumRot + r][i] =
                s0_dig_reg[NumDir - 1 - ((i + NumDir - r) % NumDir)];
        end
    end

    for (genvar l = 0; l < NumLane; l++)
    begin : g_lane
        gpc_lane u_lane (
            .digits (rot_dig[l]),
            .res    (lane_res[l])
        );
    end

    // direction counts from the unrotated lane
    always_comb
    begin
        n_hi = '0;
        n_lo = '0;
        for (int i = 0; i < NumDir; i++)
        begin
            n_hi = n_hi + CntW'(lane_res[0].hi_mask[i]);
            n_lo = n_lo + CntW'(lane_res[0].lo_mask[i]);
        end
    end

    gpc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (merge_ready),
        .lanes     (lane_res),
        .n_hi      (n_hi),
        .n_lo      (n_lo),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {(OutDataW - OutFieldW)'(0), out_item};

`ifndef ASSERT_OFF
    // the two counts never cover more than eight directions
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (5'(out_item.count_higher) + 5'(out_item.count_lower) <= 5'd8))
        else $error("direction counts exceed eight");

    // code zero means every direction is lower
    a_all_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_item.canonical_code == '0) |->
        (out_item.count_lower == 4'd8 && out_item.lower_mask == 8'hFF))
        else $error("zero code without all-lower pattern");

    // the canonical code stays in base-3 range
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_item.canonical_code <= CODE_MAX))
        else $error("canonical code out of range");
`endif

endmodule
